// ===== rtl/core/mrhsm_pkg.sv =====
package mrhsm_pkg;

    // Machine modes
    typedef enum logic [2:0] {
        MODE_READY    = 3'd0,
        MODE_RUNNING  = 3'd1,
        MODE_JOGGING  = 3'd2,
        MODE_STOPPING = 3'd3,
        MODE_HOLDING  = 3'd4,
        MODE_ESTOPPED = 3'd5
    } mode_t;

    // Hold reasons
    typedef enum logic [2:0] {
        WHY_USER_PAUSE     = 3'd0,
        WHY_USER_STOP      = 3'd1,
        WHY_PROGRAM_PAUSE  = 3'd2,
        WHY_OPTIONAL_PAUSE = 3'd3,
        WHY_SWITCH_FOUND   = 3'd4
    } reason_t;

    // Event kinds; codes above KIND_FLUSH carry no action
    typedef enum logic [3:0] {
        KIND_TICK       = 4'd0,
        KIND_SEEK_HOLD  = 4'd1,
        KIND_HOLDING    = 4'd2,
        KIND_RUNNING    = 4'd3,
        KIND_JOGGING    = 4'd4,
        KIND_IDLE       = 4'd5,
        KIND_ESTOP      = 4'd6,
        KIND_PAUSE      = 4'd7,
        KIND_PAUSE_EXEC = 4'd8,
        KIND_STOP       = 4'd9,
        KIND_UNPAUSE    = 4'd10,
        KIND_RESUME     = 4'd11,
        KIND_FLUSH      = 4'd12
    } kind_t;

    // Pause types
    typedef enum logic [1:0] {
        PTYPE_USER     = 2'd0,
        PTYPE_PROGRAM  = 2'd1,
        PTYPE_OPTIONAL = 2'd2,
        PTYPE_UNKNOWN  = 2'd3
    } ptype_t;

    // One event item
    typedef struct packed {
        logic [3:0] kind;
        logic [1:0] pause_type;
        logic       estop_active;
        logic       stepper_busy;
        logic       queue_has_moves;
    } event_t;

    // One result item
    typedef struct packed {
        logic [2:0]  machine_state;
        logic [2:0]  halt_cause;
        logic [15:0] change_count;
        logic        is_flushing;
        logic        is_resuming;
        logic        flush_queue_pulse;
        logic        stop_actions_pulse;
        logic        push_pause_pulse;
        logic [1:0]  pushed_pause_type;
    } result_t;

    // Sequencer state
    typedef struct packed {
        mode_t       mode;
        reason_t     reason;
        logic [15:0] changes;
        logic        flush_flag;
        logic        resume_flag;
        logic        stop_pending;
        logic        pause_pending;
        logic        unpause_pending;
    } ctl_state_t;

    // Move to a new mode; same mode or estopped leaves everything as is
    function automatic ctl_state_t go_mode(ctl_state_t s, mode_t nxt);
        ctl_state_t r;
        r = s;
        if (s.mode != nxt && s.mode != MODE_ESTOPPED)
        begin
            r.mode    = nxt;
            r.changes = s.changes + 16'd1;
        end
        return r;
    endfunction

    // Stop: the strobe is raised for jogging, ready and holding
    function automatic logic stop_strobe_of(ctl_state_t s);
        return (s.mode == MODE_JOGGING) || (s.mode == MODE_READY)
            || (s.mode == MODE_HOLDING);
    endfunction

    function automatic ctl_state_t do_stop(ctl_state_t s);
        ctl_state_t r;
        r = s;
        r.reason = WHY_USER_STOP;
        if (s.mode == MODE_RUNNING)
        begin
            r = go_mode(r, MODE_STOPPING);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/mrhsm_core.sv =====
module mrhsm_core
    import mrhsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  event_t  item,
    output result_t res_next
);

    ctl_state_t st_reg;
    ctl_state_t st_next;

    // Apply one event to the state and form its result
    always_comb
    begin
        ctl_state_t s;
        logic       flush_strobe;
        logic       stop_strobe;
        logic       push_strobe;
        logic [1:0] push_type;

        s            = st_reg;
        flush_strobe = 1'b0;
        stop_strobe  = 1'b0;
        push_strobe  = 1'b0;
        push_type    = 2'd0;

        unique case (item.kind)
            KIND_TICK:
            begin
                if (!item.estop_active)
                begin
                    if (s.pause_pending)
                    begin
                        if (s.mode == MODE_RUNNING)
                        begin
                            s.reason = WHY_USER_PAUSE;
                            s        = go_mode(s, MODE_STOPPING);
                        end
                        s.pause_pending = 1'b0;
                    end
                    if (s.stop_pending)
                    begin
                        stop_strobe    = stop_strobe_of(s);
                        s              = do_stop(s);
                        s.stop_pending = 1'b0;
                    end
                    if (s.flush_flag && !item.stepper_busy
                        && (s.mode == MODE_READY || s.mode == MODE_HOLDING))
                    begin
                        flush_strobe = 1'b1;
                        if (s.resume_flag)
                        begin
                            s.flush_flag  = 1'b0;
                            s.resume_flag = 1'b0;
                        end
                    end
                    if (s.unpause_pending && !s.flush_flag && s.mode != MODE_STOPPING)
                    begin
                        s.unpause_pending = 1'b0;
                        if (s.mode == MODE_HOLDING)
                        begin
                            s = go_mode(s, item.queue_has_moves ? MODE_RUNNING : MODE_READY);
                        end
                    end
                end
            end
            KIND_SEEK_HOLD:
            begin
                if (s.mode == MODE_RUNNING)
                begin
                    s.reason = WHY_SWITCH_FOUND;
                    s        = go_mode(s, MODE_STOPPING);
                end
            end
            KIND_HOLDING:
            begin
                s = go_mode(s, MODE_HOLDING);
                if (s.reason == WHY_USER_STOP)
                begin
                    stop_strobe = stop_strobe_of(s);
                    s           = do_stop(s);
                end
            end
            KIND_RUNNING:
            begin
                if (s.mode == MODE_READY)
                begin
                    s = go_mode(s, MODE_RUNNING);
                end
            end
            KIND_JOGGING:
            begin
                if (s.mode == MODE_READY || s.mode == MODE_HOLDING)
                begin
                    s = go_mode(s, MODE_JOGGING);
                end
            end
            KIND_IDLE:
            begin
                if (s.mode == MODE_RUNNING || s.mode == MODE_JOGGING)
                begin
                    s = go_mode(s, MODE_READY);
                end
            end
            KIND_ESTOP:
            begin
                s = go_mode(s, MODE_ESTOPPED);
            end
            KIND_PAUSE:
            begin
                if (item.pause_type == PTYPE_USER)
                begin
                    s.pause_pending = 1'b1;
                end
                else
                begin
                    push_strobe = 1'b1;
                    push_type   = item.pause_type;
                end
            end
            KIND_PAUSE_EXEC:
            begin
                if (item.pause_type == PTYPE_OPTIONAL || item.pause_type == PTYPE_PROGRAM)
                begin
                    s.reason = (item.pause_type == PTYPE_OPTIONAL)
                             ? WHY_OPTIONAL_PAUSE : WHY_PROGRAM_PAUSE;
                    s = go_mode(s, MODE_HOLDING);
                end
            end
            KIND_STOP:
            begin
                s.stop_pending = 1'b1;
            end
            KIND_UNPAUSE:
            begin
                s.unpause_pending = 1'b1;
            end
            KIND_RESUME:
            begin
                if (s.flush_flag)
                begin
                    s.resume_flag = 1'b1;
                end
            end
            KIND_FLUSH:
            begin
                s.flush_flag = 1'b1;
            end
            default:
            begin
                s = st_reg;
            end
        endcase

        st_next = s;

        res_next.machine_state      = s.mode;
        res_next.halt_cause         = s.reason;
        res_next.change_count       = s.changes;
        res_next.is_flushing        = s.flush_flag && !s.resume_flag;
        res_next.is_resuming        = s.resume_flag;
        res_next.flush_queue_pulse  = flush_strobe;
        res_next.stop_actions_pulse = stop_strobe;
        res_next.push_pause_pulse   = push_strobe;
        res_next.pushed_pause_type  = push_type;
    end

    // Hold state; advance on each transfer into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode            <= MODE_READY;
            st_reg.reason          <= WHY_USER_PAUSE;
            st_reg.changes         <= 16'd0;
            st_reg.flush_flag      <= 1'b1;
            st_reg.resume_flag     <= 1'b0;
            st_reg.stop_pending    <= 1'b0;
            st_reg.pause_pending   <= 1'b0;
            st_reg.unpause_pending <= 1'b0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== rtl/core/motion_run_hold_state_machine_unit.sv =====
// Channel   Direction  Handshake            Payload
// ev        in         ev_valid / ev_stall   ev_data  (event_t)
// res       out        res_valid / res_stall res_data (result_t)
//
// One item per cycle sustained while the result is not stalled; the input
// register loads at the event transfer, then the result register on advance.
// The state update for one event is a single combinational pass in mrhsm_core.
// Reset puts the sequencer in ready with a flush pending and no results held.
// A stalled result keeps its register; one more event is still taken into the
// input register, after which ev_stall rises until the result is transferred.
module motion_run_hold_state_machine_unit
    import mrhsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    ev_valid,
    output logic    ev_stall,
    input  event_t  ev_data,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res_data
);

    event_t  item_reg;
    logic    item_valid_reg;
    result_t res_reg;
    logic    res_valid_reg;
    result_t res_next;
    logic    advance;

    // Move the held event into the result register when that register frees up
    assign advance  = item_valid_reg && (!res_valid_reg || !res_stall);
    assign ev_stall = item_valid_reg && !advance;

    // Hold the accepted event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (ev_valid && !ev_stall)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_valid && !ev_stall)
        begin
            item_reg <= ev_data;
        end
    end

    mrhsm_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (item_reg),
        .res_next (res_next)
    );

    // Hold the result until transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

`ifndef SYNTH
    // Estopped is never left from one result to the next
    a_estop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid_reg && res_reg.machine_state == MODE_ESTOPPED)
        |-> res_next.machine_state == MODE_ESTOPPED)
        else $error("estopped mode was left");

    // The change count steps by one exactly when the mode changes
    a_count_tracks_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid_reg)
        |-> (16'(res_next.change_count - res_reg.change_count)
             == ((res_next.machine_state != res_reg.machine_state) ? 16'd1 : 16'd0)))
        else $error("change count out of step with mode");

    // A pushed pause type appears only with the push strobe
    a_push_type_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !res_next.push_pause_pulse) |-> res_next.pushed_pause_type == 2'd0)
        else $error("pause type without push");
`endif

endmodule
